// ===== src/dbqd_pkg.sv =====
// Shared types, constants and the quadrature transition table for the
// button debounce and quadrature detent core. Depends on nothing.
`timescale 1ns / 1ps

package dbqd_pkg;

  localparam int BUTTONS = 4;
  localparam int IDX_W = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
  localparam int MAX_EV = BUTTONS + 2;
  localparam int CNT_W = $clog2(MAX_EV + 1);

  localparam int DEBOUNCE_W = 8;
  localparam int DETENT_W = 3;
  localparam int TIME_W = 32;
  localparam int CODE_W = 3;
  localparam int INDEX_W = 2;
  localparam int MASK_W = 4;
  localparam int PROG_W = 4;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 8'd8;
  localparam logic [DETENT_W-1:0] DETENT_RESET = 3'd3;
  localparam logic [1:0] PHASE_IDLE = 2'b11;

  // Configuration register indexes
  localparam logic REG_DEBOUNCE_TIME = 1'b0;
  localparam logic REG_DETENT_THRESHOLD = 1'b1;

  typedef enum logic [CODE_W-1:0] {
    EV_FWD     = 3'd0,
    EV_BACK    = 3'd1,
    EV_PRESS   = 3'd2,
    EV_RELEASE = 3'd3,
    EV_ALL     = 3'd4
  } event_code_t;

  typedef struct packed {
    event_code_t          code;
    logic [INDEX_W-1:0]   index;
    logic [MASK_W-1:0]    mask;
  } event_t;

  typedef struct packed {
    logic stab;    // current stable pressed state of the button
    logic toggle;  // stable state changes on this sample
    logic press;   // direction of the change: 1 press, 0 release
  } lane_res_t;

  typedef struct packed {
    logic fwd;
    logic back;
  } enc_res_t;

  // Direction of a phase transition {previous, current}: +1, -1 or 0 if illegal.
  function automatic logic signed [1:0] step_dir(input logic [3:0] t);
    logic signed [1:0] d;
    unique case (t)
      4'h2, 4'h4, 4'hB, 4'hD: d = 2'sd1;
      4'h1, 4'h7, 4'h8, 4'hE: d = -2'sd1;
      default:                d = 2'sd0;
    endcase
    return d;
  endfunction

endpackage

// ===== src/dbqd_button_lane.sv =====
// One button debounce lane: candidate/stable levels and the hold timer.
// Depends on dbqd_pkg.
`timescale 1ns / 1ps

module dbqd_button_lane (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 scan,
  input  logic                                 level,
  input  logic [dbqd_pkg::DEBOUNCE_W-1:0]      debounce_time,
  input  logic [dbqd_pkg::DEBOUNCE_W-1:0]      elapsed,
  output dbqd_pkg::lane_res_t                  res
);

  logic                              cand;
  logic                              stab;
  logic [dbqd_pkg::DEBOUNCE_W-1:0]   hold;

  logic                              raw;
  logic [dbqd_pkg::DEBOUNCE_W-1:0]   rem;
  logic [dbqd_pkg::DEBOUNCE_W-1:0]   add;
  logic [dbqd_pkg::DEBOUNCE_W-1:0]   hold_sum;
  logic                              hit;

  always_comb begin
    raw = ~level;
    rem = (hold >= debounce_time) ? '0 : debounce_time - hold;
    add = (elapsed < rem) ? elapsed : rem;
    // Cannot wrap: the sum never exceeds the larger of hold and debounce_time.
    hold_sum = hold + add;
    hit = (raw == cand) && (raw != stab) && (hold_sum >= debounce_time);
    res.stab = stab;
    res.toggle = scan && hit;
    res.press = raw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cand <= 1'b0;
      stab <= 1'b0;
      hold <= '0;
    end else if (scan) begin
      if (raw != cand) begin
        cand <= raw;
        hold <= '0;
      end else if (raw == stab) begin
        hold <= '0;
      end else if (hit) begin
        stab <= ~stab;
        hold <= '0;
      end else begin
        hold <= hold_sum;
      end
    end
  end

endmodule

// ===== src/dbqd_encoder.sv =====
// Quadrature phase tracker with detent progress counter.
// Depends on dbqd_pkg for the transition table.
`timescale 1ns / 1ps

module dbqd_encoder (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               step,
  input  logic [1:0]                         phase,
  input  logic [dbqd_pkg::DETENT_W-1:0]      detent_threshold,
  output dbqd_pkg::enc_res_t                 res
);

  logic [1:0]                           last_phase;
  logic signed [dbqd_pkg::PROG_W-1:0]   progress;

  logic                                 moved;
  logic signed [1:0]                    dir;
  logic signed [dbqd_pkg::PROG_W:0]     sum;
  logic signed [dbqd_pkg::PROG_W:0]     thr;
  logic signed [dbqd_pkg::PROG_W-1:0]   progress_next;
  logic signed [dbqd_pkg::PROG_W:0]     prog_ext;
  logic                                 at_idle;

  always_comb begin
    moved = phase != last_phase;
    dir = dbqd_pkg::step_dir({last_phase, phase});
    sum = {progress[dbqd_pkg::PROG_W-1], progress}
        + {{(dbqd_pkg::PROG_W - 1){dir[1]}}, dir};
    priority if (dir == 2'sd0) progress_next = '0;
    else if (sum > 5'sd7) progress_next = 4'sd7;
    else if (sum < -5'sd8) progress_next = -4'sd8;
    else progress_next = sum[dbqd_pkg::PROG_W-1:0];
    prog_ext = {progress_next[dbqd_pkg::PROG_W-1], progress_next};
    thr = $signed({2'b00, detent_threshold});
    at_idle = step && moved && (phase == dbqd_pkg::PHASE_IDLE);
    res.fwd = at_idle && (prog_ext >= thr);
    res.back = at_idle && !res.fwd && (prog_ext <= -thr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_phase <= dbqd_pkg::PHASE_IDLE;
      progress <= '0;
    end else if (step && moved) begin
      last_phase <= phase;
      progress <= (phase == dbqd_pkg::PHASE_IDLE) ? '0 : progress_next;
    end
  end

endmodule

// ===== src/dbqd_merge.sv =====
// Merges the encoder result and the button lane results of one sample into
// an ordered, packed event list. Depends on dbqd_pkg.
`timescale 1ns / 1ps

module dbqd_merge (
  input  logic                               scan,
  input  dbqd_pkg::enc_res_t                 enc,
  input  dbqd_pkg::lane_res_t                lanes [dbqd_pkg::BUTTONS],
  output dbqd_pkg::event_t                   list [dbqd_pkg::MAX_EV],
  output logic [dbqd_pkg::CNT_W-1:0]         count
);

  logic [dbqd_pkg::CNT_W-1:0]      pos;
  logic [dbqd_pkg::BUTTONS-1:0]    mask;

  always_comb begin
    for (int j = 0; j < dbqd_pkg::MAX_EV; j++) begin
      list[j] = '0;
    end
    pos = '0;
    for (int i = 0; i < dbqd_pkg::BUTTONS; i++) begin
      mask[i] = lanes[i].stab;
    end

    // Encoder events carry the mask from before the button scan.
    if (enc.fwd || enc.back) begin
      list[pos[dbqd_pkg::CNT_W-1:0]].code = enc.fwd ? dbqd_pkg::EV_FWD : dbqd_pkg::EV_BACK;
      list[pos[dbqd_pkg::CNT_W-1:0]].mask = dbqd_pkg::MASK_W'(mask);
      pos = pos + 1'b1;
    end

    for (int i = 0; i < dbqd_pkg::BUTTONS; i++) begin
      if (lanes[i].toggle) begin
        mask[i] = ~mask[i];
        list[pos].code = lanes[i].press ? dbqd_pkg::EV_PRESS : dbqd_pkg::EV_RELEASE;
        list[pos].index = dbqd_pkg::INDEX_W'(i);
        list[pos].mask = dbqd_pkg::MASK_W'(mask);
        pos = pos + 1'b1;
      end
    end

    if (scan && (&mask)) begin
      list[pos].code = dbqd_pkg::EV_ALL;
      list[pos].mask = dbqd_pkg::MASK_W'(mask);
      pos = pos + 1'b1;
    end
    count = pos;
  end

endmodule

// ===== src/button_debounce_and_quadrature_detent_core.sv =====
// Top level of the button debounce and quadrature detent core.
// Depends on dbqd_pkg, dbqd_button_lane, dbqd_encoder and dbqd_merge.
//
// Usage: each transfer on the input channel (in_valid, in_stall) is one pin
// sample: active-low button levels, encoder A and B levels and a millisecond
// timestamp. Every sample is evaluated in the cycle it is accepted: four
// debounce lanes and the encoder tracker run side by side, and a merge stage
// packs their events (encoder first, then presses and releases in button
// order, then all held) into an event batch of up to six entries.
// The batch drains one event per cycle, unless the receiver stalls, into the
// output register; the output channel (out_valid, out_stall) shows an event
// once its sample is in the batch and the event in the output register, and
// last_event marks the final event of a sample. Throughput: one sample per
// cycle while samples raise no events. A sample with events holds the input
// back until its last event is being taken; the single-entry output register
// sets this. When the receiver stalls, the output register holds its event, the
// batch stops draining and in_stall rises once the batch cannot take another.
// Configuration writes (cfg_valid, cfg_ready, always ready) are applied at
// once. Reset returns debounce_time to 8, detent_threshold to 3, all buttons
// to released, the encoder to idle and empties the batch and output.
`timescale 1ns / 1ps

module button_debounce_and_quadrature_detent_core (
  input  logic                                   clk,
  input  logic                                   rst,

  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [dbqd_pkg::BUTTONS-1:0]           button_levels,
  input  logic                                   encoder_a_level,
  input  logic                                   encoder_b_level,
  input  logic [dbqd_pkg::TIME_W-1:0]            now_ms,

  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [dbqd_pkg::CODE_W-1:0]            event_code,
  output logic [dbqd_pkg::INDEX_W-1:0]           button_index,
  output logic [dbqd_pkg::MASK_W-1:0]            pressed_mask,
  output logic                                   last_event,

  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic                                   cfg_index,
  input  logic [dbqd_pkg::DEBOUNCE_W-1:0]        cfg_data
);

  logic [dbqd_pkg::DEBOUNCE_W-1:0]   debounce_time;
  logic [dbqd_pkg::DETENT_W-1:0]     detent_threshold;
  logic [dbqd_pkg::TIME_W-1:0]       last_scan_time;

  dbqd_pkg::event_t                  batch [dbqd_pkg::MAX_EV];
  logic [dbqd_pkg::CNT_W-1:0]        cnt;

  logic                              in_acc;
  logic                              take;
  logic                              scan;
  logic [dbqd_pkg::TIME_W-1:0]       time_gap;
  logic [dbqd_pkg::DEBOUNCE_W-1:0]   elapsed;

  dbqd_pkg::lane_res_t               lanes [dbqd_pkg::BUTTONS];
  dbqd_pkg::enc_res_t                enc;
  dbqd_pkg::event_t                  list [dbqd_pkg::MAX_EV];
  logic [dbqd_pkg::CNT_W-1:0]        list_cnt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_time <= dbqd_pkg::DEBOUNCE_RESET;
      detent_threshold <= dbqd_pkg::DETENT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        dbqd_pkg::REG_DEBOUNCE_TIME:    debounce_time <= cfg_data;
        dbqd_pkg::REG_DETENT_THRESHOLD:
          detent_threshold <= cfg_data[dbqd_pkg::DETENT_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake between the batch and the output register, the input stall and the clamped scan time.
  always_comb begin
    take = (cnt != '0) && (!out_valid || !out_stall);
    in_stall = (cnt > dbqd_pkg::CNT_W'(1)) || ((cnt == dbqd_pkg::CNT_W'(1)) && !take);
    in_acc = in_valid && !in_stall;
    time_gap = now_ms - last_scan_time;
    scan = in_acc && (time_gap != '0);
    if ((|time_gap[dbqd_pkg::TIME_W-1:dbqd_pkg::DEBOUNCE_W])
        || (time_gap[dbqd_pkg::DEBOUNCE_W-1:0] > debounce_time)) begin
      elapsed = debounce_time;
    end else begin
      elapsed = time_gap[dbqd_pkg::DEBOUNCE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_scan_time <= '0;
    end else if (scan) begin
      last_scan_time <= now_ms;
    end
  end

  for (genvar i = 0; i < dbqd_pkg::BUTTONS; i++) begin : g_lane
    dbqd_button_lane u_lane (
      .clk           (clk),
      .rst           (rst),
      .scan          (scan),
      .level         (button_levels[i]),
      .debounce_time (debounce_time),
      .elapsed       (elapsed),
      .res           (lanes[i])
    );
  end

  dbqd_encoder u_encoder (
    .clk              (clk),
    .rst              (rst),
    .step             (in_acc),
    .phase            ({encoder_a_level, encoder_b_level}),
    .detent_threshold (detent_threshold),
    .res              (enc)
  );

  dbqd_merge u_merge (
    .scan  (scan),
    .enc   (enc),
    .lanes (lanes),
    .list  (list),
    .count (list_cnt)
  );

  // An accepted sample always finds the batch empty or emptying this cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (in_acc) begin
      cnt <= list_cnt;
    end else if (take) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      batch <= list;
    end else if (take) begin
      for (int j = 0; j < dbqd_pkg::MAX_EV - 1; j++) begin
        batch[j] <= batch[j + 1];
      end
      batch[dbqd_pkg::MAX_EV - 1] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      event_code <= batch[0].code;
      button_index <= batch[0].index;
      pressed_mask <= batch[0].mask;
      last_event <= cnt == dbqd_pkg::CNT_W'(1);
    end
  end

endmodule

// ===== src/dbqd_checker.sv =====
// Port-level checker for the button debounce and quadrature detent core,
// bound to the top level. Depends on dbqd_pkg.
`timescale 1ns / 1ps

module dbqd_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [dbqd_pkg::CODE_W-1:0]       event_code,
  input logic [dbqd_pkg::INDEX_W-1:0]      button_index,
  input logic [dbqd_pkg::MASK_W-1:0]       pressed_mask,
  input logic                              last_event
);

  // A stalled event must not change under the receiver.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(event_code)
      && $stable(button_index) && $stable(pressed_mask) && $stable(last_event))
    else $error("stalled output event changed");

  // Only press and release events name a button.
  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_code == dbqd_pkg::EV_FWD || event_code == dbqd_pkg::EV_BACK
      || event_code == dbqd_pkg::EV_ALL) |-> button_index == '0)
    else $error("button index set on a non-button event");

  // An all-held event reports every button pressed and closes its sample.
  a_all_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_code == dbqd_pkg::EV_ALL |-> (&pressed_mask) && last_event)
    else $error("all-held event with incomplete mask or not last");

  // A press leaves its button in the mask, a release clears it; only the press side is asserted.
  a_press_mask: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_code == dbqd_pkg::EV_PRESS |-> pressed_mask[button_index])
    else $error("press event without its button in the mask");

  // Nothing is presented and the input is open in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !in_stall)
    else $error("output valid or input stalled straight after reset");

endmodule

bind button_debounce_and_quadrature_detent_core dbqd_checker u_dbqd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .event_code   (event_code),
  .button_index (button_index),
  .pressed_mask (pressed_mask),
  .last_event   (last_event)
);

// ===== tb/dbqd_event_checker.sv =====
// Event checker for the button debounce and quadrature detent core.
// It watches the sample, event and register channels, predicts the events of each sample
// and compares every event transfer against them. Depends on dbqd_pkg.
`timescale 1ns / 1ps

module dbqd_event_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [dbqd_pkg::BUTTONS-1:0]    button_levels,
  input  logic                            encoder_a_level,
  input  logic                            encoder_b_level,
  input  logic [dbqd_pkg::TIME_W-1:0]     now_ms,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [dbqd_pkg::CODE_W-1:0]     event_code,
  input  logic [dbqd_pkg::INDEX_W-1:0]    button_index,
  input  logic [dbqd_pkg::MASK_W-1:0]     pressed_mask,
  input  logic                            last_event,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic                            cfg_index,
  input  logic [dbqd_pkg::DEBOUNCE_W-1:0] cfg_data,
  output int                              fault_count,
  output int                              events_owed
);
  import dbqd_pkg::*;

  typedef struct packed {
    event_code_t        code;
    logic [INDEX_W-1:0] index;
    logic [MASK_W-1:0]  mask;
    logic               last;
  } pin_event_t;

  // Register copies
  logic [DEBOUNCE_W-1:0] bounce_limit;
  logic [DETENT_W-1:0]   detent_steps;

  // Debounce and encoder state
  logic [MASK_W-1:0]        stable_mask;
  logic [MASK_W-1:0]        candidate_mask;
  logic [DEBOUNCE_W-1:0]    held_ms [BUTTONS];
  logic [1:0]               prev_phase;
  logic signed [PROG_W-1:0] progress;
  logic [TIME_W-1:0]        scan_ms;

  pin_event_t sample_events[$];
  pin_event_t owed_events[$];

  function automatic void note_event(input event_code_t code, input logic [INDEX_W-1:0] idx);
    sample_events.push_back('{code: code, index: idx, mask: stable_mask, last: 1'b0});
  endfunction

  task automatic report_fault(input string what);
    if (fault_count < 10)
      $display("%s", what);
    fault_count++;
  endtask

  task automatic predict_events(input logic [BUTTONS-1:0] levels, input logic [1:0] phase,
                                input logic [TIME_W-1:0] stamp);
    int                    dir;
    int                    steps;
    int                    limit;
    logic [TIME_W-1:0]     gap;
    logic [DEBOUNCE_W-1:0] step_ms;
    logic [DEBOUNCE_W-1:0] room;
    logic [BUTTONS-1:0]    want;
    pin_event_t            ev;
    sample_events.delete();

    // Encoder: the forward walk is 3, 1, 0, 2, 3, so the forward successor of
    // {a, b} is {~b, a} and the backward one is {b, ~a}.
    if (phase != prev_phase) begin
      if (phase == {~prev_phase[0], prev_phase[1]})
        dir = 1;
      else if (phase == {prev_phase[0], ~prev_phase[1]})
        dir = -1;
      else
        dir = 0;
      steps = (dir == 0) ? 0 : int'(progress) + dir;
      if (steps > 7)
        steps = 7;
      if (steps < -8)
        steps = -8;
      progress = PROG_W'(steps);
      prev_phase = phase;
      if (phase == PHASE_IDLE) begin
        limit = int'(detent_steps);
        if (steps >= limit)
          note_event(EV_FWD, '0);
        else if (steps <= -limit)
          note_event(EV_BACK, '0);
        progress = '0;
      end
    end

    // Buttons are only scanned when the millisecond counter has moved.
    gap = stamp - scan_ms;
    if (gap != '0) begin
      scan_ms = stamp;
      step_ms = (gap > TIME_W'(bounce_limit)) ? bounce_limit : gap[DEBOUNCE_W-1:0];
      want = ~levels;
      for (int i = 0; i < BUTTONS; i++) begin
        if (want[i] != candidate_mask[i]) begin
          candidate_mask[i] = want[i];
          held_ms[i] = '0;
        end else if (want[i] == stable_mask[i]) begin
          held_ms[i] = '0;
        end else begin
          room = (held_ms[i] >= bounce_limit) ? '0 : bounce_limit - held_ms[i];
          held_ms[i] += (step_ms < room) ? step_ms : room;
          if (held_ms[i] >= bounce_limit) begin
            stable_mask[i] = want[i];
            held_ms[i] = '0;
            note_event(want[i] ? EV_PRESS : EV_RELEASE, INDEX_W'(i));
          end
        end
      end
      if (&stable_mask)
        note_event(EV_ALL, '0);
    end

    foreach (sample_events[k]) begin
      ev = sample_events[k];
      ev.last = (k == sample_events.size() - 1);
      owed_events.push_back(ev);
    end
  endtask

  always @(posedge clk) begin : watch
    pin_event_t due;
    if (rst) begin
      bounce_limit = DEBOUNCE_RESET;
      detent_steps = DETENT_RESET;
      stable_mask = '0;
      candidate_mask = '0;
      foreach (held_ms[i])
        held_ms[i] = '0;
      prev_phase = PHASE_IDLE;
      progress = '0;
      scan_ms = '0;
      owed_events.delete();
      fault_count = 0;
    end else begin
      // An event transfer always belongs to an earlier sample, so it is
      // matched before this edge's sample adds its own events.
      if (out_valid && !out_stall) begin
        if (owed_events.size() == 0) begin
          report_fault($sformatf("unexpected event: code %0d button %0d mask %h last %0d",
                                 event_code, button_index, pressed_mask, last_event));
        end else begin
          due = owed_events.pop_front();
          if (event_code !== due.code || button_index !== due.index ||
              pressed_mask !== due.mask || last_event !== due.last)
            report_fault($sformatf({"event mismatch: expected code %0d button %0d mask %h ",
                                    "last %0d, got code %0d button %0d mask %h last %0d"},
                                   due.code, due.index, due.mask, due.last,
                                   event_code, button_index, pressed_mask, last_event));
        end
      end
      if (in_valid && !in_stall)
        predict_events(button_levels, {encoder_a_level, encoder_b_level}, now_ms);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DEBOUNCE_TIME:    bounce_limit = cfg_data;
          REG_DETENT_THRESHOLD: detent_steps = cfg_data[DETENT_W-1:0];
          default: ;
        endcase
      end
    end
    events_owed = owed_events.size();
  end

endmodule

// ===== tb/button_debounce_and_quadrature_detent_core_tb.sv =====
// Testbench top for the button debounce and quadrature detent core: drives
// directed and random pin samples and register writes and gives the verdict.
// Depends on dbqd_pkg, the core and dbqd_event_checker.
`timescale 1ns / 1ps

module button_debounce_and_quadrature_detent_core_tb;
  import dbqd_pkg::*;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [BUTTONS-1:0]    button_levels;
  logic                  encoder_a_level;
  logic                  encoder_b_level;
  logic [TIME_W-1:0]     now_ms;
  logic                  out_valid;
  logic                  out_stall;
  logic [CODE_W-1:0]     event_code;
  logic [INDEX_W-1:0]    button_index;
  logic [MASK_W-1:0]     pressed_mask;
  logic                  last_event;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic                  cfg_index;
  logic [DEBOUNCE_W-1:0] cfg_data;

  int fault_count;
  int events_owed;

  // Transfers seen at the last rising edge, read back at the falling edge.
  bit sample_taken = 1'b0;
  bit event_taken  = 1'b0;
  bit cfg_taken    = 1'b0;

  bit tx_idle_on  = 1'b1;
  bit rx_stall_on = 1'b1;
  int rx_hold     = 0;

  // Pin state carried between random samples
  logic [BUTTONS-1:0] pins;
  logic [1:0]         enc_phase;
  logic [TIME_W-1:0]  clock_ms;
  bit                 turn_fwd;

  logic [DEBOUNCE_W-1:0] debounce_plan [6] = '{8'd1, 8'd255, 8'd0, 8'd20, 8'd3, 8'd8};
  logic [DETENT_W-1:0]   detent_plan   [6] = '{3'd1, 3'd4, 3'd0, 3'd7, 3'd2, 3'd5};

  button_debounce_and_quadrature_detent_core uut (.*);

  dbqd_event_checker monitor (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  always @(posedge clk) begin
    sample_taken = in_valid && !in_stall;
    event_taken  = out_valid && !out_stall;
    cfg_taken    = cfg_valid && cfg_ready;
  end

  // The receiver draws a fresh stall length after every event transfer.
  always @(negedge clk) begin
    if (event_taken)
      rx_hold = rx_stall_on ? $urandom_range(0, 18) : 0;
    out_stall <= (rx_hold != 0);
    if (rx_hold != 0)
      rx_hold--;
  end

  function automatic logic [1:0] quad_next(input logic [1:0] p, input bit fwd);
    return fwd ? {~p[0], p[1]} : {p[0], ~p[1]};
  endfunction

  task automatic send_sample(input logic [BUTTONS-1:0] levels, input logic [1:0] phase,
                             input logic [TIME_W-1:0] stamp);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 18) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    button_levels   <= levels;
    encoder_a_level <= phase[1];
    encoder_b_level <= phase[0];
    now_ms          <= stamp;
    do @(negedge clk); while (!sample_taken);
  endtask

  // Holds the sender back until every owed event has come out.
  task automatic settle();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (events_owed != 0 && guard < 20000) begin
      @(negedge clk);
      guard++;
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [DEBOUNCE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(negedge clk); while (!cfg_taken);
  endtask

  task automatic configure(input logic [DEBOUNCE_W-1:0] debounce,
                           input logic [DETENT_W-1:0] detent);
    settle();
    write_reg(REG_DEBOUNCE_TIME, debounce);
    // The upper bits are not stored, so they carry noise.
    write_reg(REG_DETENT_THRESHOLD, {5'($urandom), detent});
    cfg_valid <= 1'b0;
  endtask

  // Mostly legal detent walks and slowly changing buttons, with some bounce,
  // illegal jumps and large or wrapping time steps mixed in.
  task automatic random_sample();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 15)
      ;
    else if (pick < 60)
      clock_ms += $urandom_range(1, 3);
    else if (pick < 80)
      clock_ms += $urandom_range(1, 300);
    else if (pick < 90)
      clock_ms = $urandom;
    else
      clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3);

    pick = $urandom_range(0, 99);
    if (pick < 12)
      pins[$urandom_range(0, BUTTONS - 1)] ^= 1'b1;
    else if (pick < 17)
      pins = BUTTONS'($urandom);
    else if (pick < 22)
      pins = '0;
    else if (pick < 25)
      pins = '1;

    pick = $urandom_range(0, 99);
    if (pick < 55)
      enc_phase = quad_next(enc_phase, turn_fwd);
    else if (pick < 70)
      ;
    else if (pick < 80)
      enc_phase = quad_next(enc_phase, !turn_fwd);
    else if (pick < 90)
      enc_phase = ~enc_phase;
    else
      enc_phase = 2'($urandom);
    if (enc_phase == PHASE_IDLE && $urandom_range(0, 1) == 1)
      turn_fwd = !turn_fwd;

    send_sample(pins, enc_phase, clock_ms);
  endtask

  initial begin
    rst             = 1'b1;
    in_valid        = 1'b0;
    button_levels   = '1;
    encoder_a_level = 1'b1;
    encoder_b_level = 1'b1;
    now_ms          = '0;
    cfg_valid       = 1'b0;
    cfg_index       = REG_DEBOUNCE_TIME;
    cfg_data        = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part at the reset settings: debounce 8 ms, detent 3 steps.
    send_sample(4'hF, PHASE_IDLE, 32'd0);     // neither time nor phase moves
    send_sample(4'hE, PHASE_IDLE, 32'd1);
    send_sample(4'hE, PHASE_IDLE, 32'd20);    // long gap is clamped, button 0 pressed
    send_sample(4'h0, PHASE_IDLE, 32'd21);
    send_sample(4'h0, PHASE_IDLE, 32'd40);    // three presses, then all held
    send_sample(4'h0, PHASE_IDLE, 32'd41);    // all held repeats
    send_sample(4'h0, 2'd1, 32'd41);
    send_sample(4'h0, 2'd0, 32'd41);
    send_sample(4'h0, 2'd2, 32'd41);
    send_sample(4'h0, PHASE_IDLE, 32'd41);    // forward detent
    send_sample(4'h0, 2'd2, 32'd41);
    send_sample(4'h0, 2'd0, 32'd41);
    send_sample(4'h0, 2'd1, 32'd41);
    send_sample(4'h0, PHASE_IDLE, 32'd41);    // backward detent
    send_sample(4'h0, 2'd0, 32'd41);          // illegal jump clears progress
    send_sample(4'h0, 2'd2, 32'd41);
    send_sample(4'h0, PHASE_IDLE, 32'd41);    // too few steps for a detent
    send_sample(4'hF, PHASE_IDLE, 32'd50);
    send_sample(4'hF, 2'd1, 32'd51);
    send_sample(4'hF, 2'd0, 32'd52);
    send_sample(4'hF, 2'd2, 32'd53);
    send_sample(4'hF, PHASE_IDLE, 32'd100);   // detent followed by four releases
    send_sample(4'h0, 2'd1, 32'd101);
    send_sample(4'h0, 2'd0, 32'd102);
    send_sample(4'h0, 2'd2, 32'd103);
    send_sample(4'h0, PHASE_IDLE, 32'd200);   // detent, four presses and all held
    send_sample(4'hF, PHASE_IDLE, 32'hFFFF_FFFF);
    send_sample(4'hF, PHASE_IDLE, 32'd3);     // time wraps round

    pins      = 4'hF;
    enc_phase = PHASE_IDLE;
    clock_ms  = 32'd3;
    turn_fwd  = 1'b1;

    for (int ph = 0; ph < 6; ph++) begin
      configure(debounce_plan[ph], detent_plan[ph]);
      tx_idle_on  = (ph % 3 != 1);
      rx_stall_on = (ph % 3 != 2);
      for (int n = 0; n < 14; n++) begin
        if (n == 7)
          settle();
        random_sample();
      end
    end

    settle();
    if (fault_count == 0 && events_owed == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
